>>> design/pid_position_drive_macros.svh
// assertion macros for the pid_position_drive rtl, used in pidpd_error
// expects i_clk and i_rst_n in the scope of each use
`ifndef PID_POSITION_DRIVE_MACROS_SVH
`define PID_POSITION_DRIVE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define PIDPD_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// implication checked at the same clock edge
`define PIDPD_CHECK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> design/pidpd_pkg.sv
// shared widths, constants, codes and beat types for pid_position_drive
// no dependencies
`default_nettype none

package pidpd_pkg;

    localparam int unsigned POS_W      = 10;
    localparam int unsigned GAIN_W     = 15;
    localparam int unsigned ERR_W      = POS_W + 1;
    localparam int unsigned DELTA_W    = ERR_W + 1;
    localparam int unsigned SUM_W      = GAIN_W + 1;
    localparam int unsigned ACC_W      = SUM_W + 1;
    localparam int unsigned FRAC_W     = 12;
    localparam int unsigned P_PROD_W   = ERR_W + GAIN_W + 1;
    localparam int unsigned I_PROD_W   = SUM_W + GAIN_W + 1;
    localparam int unsigned D_PROD_W   = DELTA_W + GAIN_W + 1;
    localparam int unsigned DRIVE_W    = 8;
    localparam int unsigned EFFORT_W   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = GAIN_W;

    localparam logic signed [ERR_W-1:0]    SMALL_ERROR   = ERR_W'(5);
    localparam logic signed [EFFORT_W-1:0] EFFORT_MAX    = EFFORT_W'(127);
    localparam logic [DRIVE_W-1:0]         NEUTRAL       = DRIVE_W'(127);
    localparam logic [GAIN_W-1:0]          LIMIT_DEFAULT = GAIN_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P          = 3'd0,
        CFG_GAIN_I          = 3'd1,
        CFG_GAIN_D          = 3'd2,
        CFG_INTEGRAL_LIMIT  = 3'd3,
        CFG_FIRST_REVERSED  = 3'd4,
        CFG_SECOND_REVERSED = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [GAIN_W-1:0] integral_limit;
        logic              first_reversed;
        logic              second_reversed;
    } t_cfg;

    // error stage result
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DELTA_W-1:0] delta;
        logic signed [SUM_W-1:0]   sum;
    } t_err_beat;

    // raw products of the integer terms and the q3.12 gains, each with 12 fraction bits
    typedef struct packed {
        logic signed [P_PROD_W-1:0] p_prod;
        logic signed [I_PROD_W-1:0] i_prod;
        logic signed [D_PROD_W-1:0] d_prod;
    } t_term_beat;

endpackage

`default_nettype wire

>>> design/pidpd_error.sv
// error, delta and clamped integral stage; holds the controller state
// depends on pidpd_pkg and pid_position_drive_macros.svh
`default_nettype none

`include "pid_position_drive_macros.svh"

module pidpd_error (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pidpd_pkg::POS_W-1:0]       i_measured_position,
    input  logic [pidpd_pkg::POS_W-1:0]       i_target_position,
    input  logic [pidpd_pkg::GAIN_W-1:0]      i_integral_limit,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pidpd_pkg::t_err_beat              o_beat
);
    import pidpd_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_NEG_FULL = {1'b1, {(SUM_W-1){1'b0}}};

    logic                      r_valid;
    t_err_beat                 r_beat;
    logic signed [ERR_W-1:0]   r_last_error;
    logic signed [SUM_W-1:0]   r_error_sum;

    logic                      adv;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [DELTA_W-1:0] n_delta;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   lim_pos;
    logic signed [ACC_W-1:0]   lim_neg;
    logic signed [ACC_W-1:0]   clamped;
    logic                      small_err;
    logic signed [SUM_W-1:0]   n_sum;

    assign o_ready = !r_valid || i_ready;
    assign adv     = i_valid && o_ready;

    always_comb begin
        n_err   = $signed({1'b0, i_measured_position}) - $signed({1'b0, i_target_position});
        n_delta = $signed({r_last_error[ERR_W-1], r_last_error})
                - $signed({n_err[ERR_W-1], n_err});
        acc     = $signed({r_error_sum[SUM_W-1], r_error_sum})
                + $signed({{(ACC_W-ERR_W){n_err[ERR_W-1]}}, n_err});
        lim_pos = $signed({{(ACC_W-GAIN_W){1'b0}}, i_integral_limit});
        lim_neg = -lim_pos;
        if (acc > lim_pos) begin
            clamped = lim_pos;
        end else if (acc < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = acc;
        end
        small_err = (n_err < SMALL_ERROR) && (n_err > -SMALL_ERROR);
        // clamp keeps the magnitude within 15 bits, so the top bit is redundant
        n_sum = small_err ? '0 : clamped[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_last_error <= '0;
            r_error_sum  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (adv) begin
                r_last_error <= n_err;
                r_error_sum  <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_beat.err   <= n_err;
            r_beat.delta <= n_delta;
            r_beat.sum   <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    `PIDPD_CHECK_IMPL(a_small_err_clears_sum, r_valid && (r_beat.err < SMALL_ERROR) && (r_beat.err > -SMALL_ERROR), r_beat.sum == '0, "small error left a nonzero integral")
    `PIDPD_CHECK_IMPL(a_state_tracks_beat, r_valid, (r_last_error == r_beat.err) && (r_error_sum == r_beat.sum), "controller state out of step with held beat")
    `PIDPD_CHECK(a_sum_bounded, r_error_sum != SUM_NEG_FULL, "integral beyond the widest limit")

endmodule

`default_nettype wire

>>> design/pidpd_terms.sv
// gain multiply stage: three products of the q3.12 gains, 12 fraction bits, registered
// depends on pidpd_pkg
`default_nettype none

module pidpd_terms (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  pidpd_pkg::t_err_beat         i_beat,
    input  logic [pidpd_pkg::GAIN_W-1:0] i_gain_p,
    input  logic [pidpd_pkg::GAIN_W-1:0] i_gain_i,
    input  logic [pidpd_pkg::GAIN_W-1:0] i_gain_d,
    output logic                         o_valid,
    input  logic                         i_ready,
    output pidpd_pkg::t_term_beat        o_beat
);
    import pidpd_pkg::*;

    logic       r_valid;
    t_term_beat r_beat;
    t_term_beat n_beat;
    logic       adv;

    assign o_ready = !r_valid || i_ready;
    assign adv     = i_valid && o_ready;

    always_comb begin
        n_beat.p_prod = i_beat.err   * $signed({1'b0, i_gain_p});
        n_beat.i_prod = i_beat.sum   * $signed({1'b0, i_gain_i});
        n_beat.d_prod = i_beat.delta * $signed({1'b0, i_gain_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

>>> design/pidpd_mix.sv
// scale, sum and saturate the three terms; form the drive bytes
// depends on pidpd_pkg
`default_nettype none

module pidpd_mix (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  pidpd_pkg::t_term_beat          i_beat,
    input  logic                           i_first_reversed,
    input  logic                           i_second_reversed,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [pidpd_pkg::DRIVE_W-1:0]  o_first_drive,
    output logic [pidpd_pkg::DRIVE_W-1:0]  o_second_drive,
    output logic signed [pidpd_pkg::EFFORT_W-1:0] o_control_effort
);
    import pidpd_pkg::*;

    localparam int unsigned TOTAL_W = I_PROD_W - FRAC_W + 2;
    localparam logic signed [I_PROD_W-1:0] ROUND_BIAS =
        {{(I_PROD_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};

    // divide by 4096 rounding toward zero
    function automatic logic signed [TOTAL_W-1:0] q12_trunc(
        input logic signed [I_PROD_W-1:0] v
    );
        logic signed [I_PROD_W-1:0] biased;
        logic signed [I_PROD_W-1:0] shifted;
        biased  = v + (v[I_PROD_W-1] ? ROUND_BIAS : '0);
        shifted = biased >>> FRAC_W;
        return shifted[TOTAL_W-1:0];
    endfunction

    logic                        r_valid;
    logic [DRIVE_W-1:0]          r_first_drive;
    logic [DRIVE_W-1:0]          r_second_drive;
    logic signed [EFFORT_W-1:0]  r_control_effort;

    logic                        adv;
    logic signed [I_PROD_W-1:0]  p_ext;
    logic signed [I_PROD_W-1:0]  d_ext;
    logic signed [TOTAL_W-1:0]   total;
    logic signed [TOTAL_W-1:0]   eff_max;
    logic signed [EFFORT_W-1:0]  n_effort;
    logic [DRIVE_W-1:0]          eff_bits;
    logic [DRIVE_W-1:0]          drive_pos;
    logic [DRIVE_W-1:0]          drive_neg;

    assign o_ready = !r_valid || i_ready;
    assign adv     = i_valid && o_ready;

    always_comb begin
        p_ext   = {{(I_PROD_W-P_PROD_W){i_beat.p_prod[P_PROD_W-1]}}, i_beat.p_prod};
        d_ext   = {{(I_PROD_W-D_PROD_W){i_beat.d_prod[D_PROD_W-1]}}, i_beat.d_prod};
        total   = q12_trunc(p_ext) + q12_trunc(i_beat.i_prod) + q12_trunc(d_ext);
        eff_max = {{(TOTAL_W-EFFORT_W){1'b0}}, EFFORT_MAX};
        if (total > eff_max) begin
            n_effort = EFFORT_MAX;
        end else if (total < -eff_max) begin
            n_effort = -EFFORT_MAX;
        end else begin
            n_effort = total[EFFORT_W-1:0];
        end
        // results stay in 0..254, so modulo-256 arithmetic is exact
        eff_bits  = n_effort;
        drive_pos = NEUTRAL + eff_bits;
        drive_neg = NEUTRAL - eff_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_control_effort <= n_effort;
            r_first_drive    <= i_first_reversed  ? drive_neg : drive_pos;
            r_second_drive   <= i_second_reversed ? drive_neg : drive_pos;
        end
    end

    assign o_valid          = r_valid;
    assign o_first_drive    = r_first_drive;
    assign o_second_drive   = r_second_drive;
    assign o_control_effort = r_control_effort;

endmodule

`default_nettype wire

>>> design/pid_position_drive.sv
// a beat accepted from the inputs passes the input register, error stage, multiply stage
// and result register in that order, and is driven to the outputs from the result register
// throughput: one beat per cycle unless stalled; each stage register frees itself when
// its consumer takes the beat, so a stalled result still lets earlier stages fill
// reset: synchronous active-low; clears stage valids, integral and last error,
// and loads the gains with 0, the integral limit with 1000 and both reverse bits with 0
`default_nettype none

module pid_position_drive (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [pidpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pidpd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input beats: one control tick each
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pidpd_pkg::POS_W-1:0]       i_measured_position,
    input  logic [pidpd_pkg::POS_W-1:0]       i_target_position,
    // result beats
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pidpd_pkg::DRIVE_W-1:0]     o_first_drive,
    output logic [pidpd_pkg::DRIVE_W-1:0]     o_second_drive,
    output logic signed [pidpd_pkg::EFFORT_W-1:0] o_control_effort
);
    import pidpd_pkg::*;

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic               r_in_valid;
    logic [POS_W-1:0]   r_measured_position;
    logic [POS_W-1:0]   r_target_position;

    logic               err_ready;
    logic               err_valid;
    t_err_beat          err_beat;
    logic               terms_ready;
    logic               terms_valid;
    t_term_beat         terms_beat;
    logic               mix_ready;

    // register writes; unknown indexes fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p          <= '0;
            r_cfg.gain_i          <= '0;
            r_cfg.gain_d          <= '0;
            r_cfg.integral_limit  <= LIMIT_DEFAULT;
            r_cfg.first_reversed  <= 1'b0;
            r_cfg.second_reversed <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_data;
                end
                CFG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_data;
                end
                CFG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_data;
                end
                CFG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_data;
                end
                CFG_FIRST_REVERSED: begin
                    r_cfg.first_reversed <= i_cfg_data[0];
                end
                CFG_SECOND_REVERSED: begin
                    r_cfg.second_reversed <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register: takes a beat whenever it is empty or being drained
    assign o_ready = !r_in_valid || err_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_measured_position <= i_measured_position;
            r_target_position   <= i_target_position;
        end
    end

    // error, delta and anti-windup integral; the state updates once per beat
    pidpd_error u_error (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (r_in_valid),
        .o_ready             (err_ready),
        .i_measured_position (r_measured_position),
        .i_target_position   (r_target_position),
        .i_integral_limit    (r_cfg.integral_limit),
        .o_valid             (err_valid),
        .i_ready             (terms_ready),
        .o_beat              (err_beat)
    );

    // three gain multipliers, one per term
    pidpd_terms u_terms (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (err_valid),
        .o_ready  (terms_ready),
        .i_beat   (err_beat),
        .i_gain_p (r_cfg.gain_p),
        .i_gain_i (r_cfg.gain_i),
        .i_gain_d (r_cfg.gain_d),
        .o_valid  (terms_valid),
        .i_ready  (mix_ready),
        .o_beat   (terms_beat)
    );

    // truncate, sum, saturate and build the drive bytes into the result register
    pidpd_mix u_mix (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (terms_valid),
        .o_ready           (mix_ready),
        .i_beat            (terms_beat),
        .i_first_reversed  (r_cfg.first_reversed),
        .i_second_reversed (r_cfg.second_reversed),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_first_drive     (o_first_drive),
        .o_second_drive    (o_second_drive),
        .o_control_effort  (o_control_effort)
    );

endmodule

`default_nettype wire
